@@ hdl/prr_pkg.sv @@
package prr_pkg;

  // Request codes of the input channel.
  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_READY    = 2'd2,
    REQ_GRANT    = 2'd3
  } req_e;

  // Status codes of the result channel.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_HELD    = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_NONE    = 2'd3
  } status_e;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_GRANT,
    S_DONE
  } state_e;

  // Event type codes.
  localparam logic [2:0] EvRead       = 3'd0;
  localparam logic [2:0] EvWrite      = 3'd1;
  localparam logic [2:0] EvException  = 3'd2;
  localparam logic [2:0] EvAccept     = 3'd3;
  localparam logic [2:0] EvConnect    = 3'd4;
  localparam logic [2:0] EvDisconnect = 3'd5;
  localparam logic [2:0] EvAny        = 3'd6;

  // Kind codes of a registration.
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindExc   = 2'd2;

  localparam int unsigned KindCount = 3;
  localparam logic [KindCount-1:0] KindsAll  = 3'b111;
  localparam logic [KindCount-1:0] KindsNone = 3'b000;

  // Width of the active slot counter and its largest reachable value.
  localparam int unsigned CountW       = 7;
  localparam int unsigned MaxSlotCount = 64;

  // Kind mask of an event type: all kinds for any, none for an unknown code.
  function automatic logic [KindCount-1:0] kind_mask(input logic [2:0] ev);
    logic [KindCount-1:0] m;
    case (ev)
      EvRead, EvAccept:         m = 3'b001;
      EvWrite, EvConnect:       m = 3'b010;
      EvException, EvDisconnect: m = 3'b100;
      EvAny:                    m = KindsAll;
      default:                  m = KindsNone;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/prr_ram.sv @@
module prr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/prr_pick.sv @@
// Compares the three kinds of one slot row against the best candidate so far.
// Only a strictly lower priority displaces it, so earlier entries in rotation
// order win ties.
module prr_pick #(
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic [prr_pkg::KindCount-1:0]                pend_i,
  input  logic [prr_pkg::KindCount-1:0]                kmask_i,
  input  logic [prr_pkg::KindCount-1:0][PRIO_BITS-1:0] prio_i,
  input  logic                                         found_i,
  input  logic [PRIO_BITS-1:0]                         best_prio_i,
  output logic                                         hit_o,
  output logic [1:0]                                   kind_o,
  output logic [PRIO_BITS-1:0]                         prio_o
);

  logic                 found;
  logic [PRIO_BITS-1:0] bp;

  always_comb begin
    found  = found_i;
    bp     = best_prio_i;
    hit_o  = 1'b0;
    kind_o = '0;
    for (int k = 0; k < prr_pkg::KindCount; k++) begin
      if (pend_i[k] && kmask_i[k] && (!found || prio_i[k] < bp)) begin
        found  = 1'b1;
        bp     = prio_i[k];
        hit_o  = 1'b1;
        kind_o = 2'(k);
      end
    end
    prio_o = bp;
  end

endmodule

@@ hdl/priority_round_robin_event_arbiter.sv @@
// Event arbiter over SLOTS descriptor slots, each holding read, write and
// exception registrations with a priority. All per-slot state sits in one
// row-per-slot memory. Register, remove and mark ready read one row, write
// it back and then present their result. A grant request reads one row per
// cycle through the memory's single read port, SLOTS+1 rows in rotation
// order, drains the read pipeline, then writes back the winner and presents
// its result. After reset the block clears every memory row with in_stall_o
// high. Only one item is in flight; the output register lets the next item
// be taken while a result still waits.
module priority_round_robin_event_arbiter #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [5:0]                  slot_i,
  input  logic [2:0]                  event_type_i,
  input  logic [7:0]                  prio_i,
  input  logic [2:0]                  ready_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        grant_valid_o,
  output logic [5:0]                  grant_slot_o,
  output logic [1:0]                  grant_kind_o,
  output logic [2:0]                  grant_event_o,
  output logic [7:0]                  grant_prio_o,
  output logic [prr_pkg::CountW-1:0]  active_slots_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = AW + 1;
  localparam logic [PRIO_BITS-1:0] PrioInf = {PRIO_BITS{1'b1}};

  typedef struct packed {
    logic [prr_pkg::KindCount-1:0]                kinds;
    logic [prr_pkg::KindCount-1:0]                pend;
    logic [prr_pkg::KindCount-1:0][PRIO_BITS-1:0] prio;
    logic [prr_pkg::KindCount-1:0][2:0]           ev;
  } row_t;

  localparam int unsigned RowW = $bits(row_t);

  prr_pkg::state_e state_q, state_d;

  // Item registers.
  prr_pkg::req_e  req_q;
  logic [AW-1:0]  slot_addr_q;
  logic           slot_ok_q;
  logic [2:0]     ev_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [2:0]     rdy_q;

  // Memory ports.
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  row_t           mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [RowW-1:0] mem_rdata;
  row_t           rd_row;

  // Clearing pass and scan sequencing.
  logic [AW-1:0]  clr_addr_q;
  logic [AW-1:0]  scan_addr_q;
  logic [AW-1:0]  scan_addr_nxt;
  logic [CW-1:0]  issue_cnt_q;
  logic           issuing;
  logic           rd_vld_q;
  logic           rd_first_q;
  logic [AW-1:0]  rd_slot_q;
  logic [prr_pkg::KindCount-1:0] first_mask_q;
  logic [prr_pkg::KindCount-1:0] eval_mask;

  // Best candidate so far.
  logic           best_found_q;
  logic [AW-1:0]  best_slot_q;
  logic [1:0]     best_kind_q;
  logic [PRIO_BITS-1:0] best_prio_q;
  row_t           best_row_q;
  row_t           grant_row;
  logic           pick_hit;
  logic [1:0]     pick_kind;
  logic [PRIO_BITS-1:0] pick_prio;

  // Round-robin position.
  logic [AW-1:0]  last_slot_q;
  logic [1:0]     last_kind_q;
  logic           served_q;

  logic [prr_pkg::CountW-1:0] slot_count_q;

  // Row update for register, remove and mark ready.
  logic [prr_pkg::KindCount-1:0] acc_mask;
  logic [prr_pkg::KindCount-1:0] rm_mask;
  row_t           row_mod;
  row_t           clear_row;
  logic           acc_we;
  logic           cnt_inc;
  logic           cnt_dec;
  prr_pkg::status_e acc_status;

  // Result held until the output register is free, and the output register.
  prr_pkg::status_e res_status_q;
  logic           res_gv_q;
  logic [5:0]     res_gs_q;
  logic [1:0]     res_gk_q;
  logic [2:0]     res_ge_q;
  logic [7:0]     res_gp_q;

  logic           out_valid_q;
  prr_pkg::status_e out_status_q;
  logic           out_gv_q;
  logic [5:0]     out_gs_q;
  logic [1:0]     out_gk_q;
  logic [2:0]     out_ge_q;
  logic [7:0]     out_gp_q;
  logic [prr_pkg::CountW-1:0] out_cnt_q;

  logic           in_xfer;
  logic           out_free;

  prr_ram #(
    .WIDTH (RowW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_row = mem_rdata;

  prr_pick #(
    .PRIO_BITS (PRIO_BITS)
  ) u_pick (
    .pend_i      (rd_row.pend),
    .kmask_i     (eval_mask),
    .prio_i      (rd_row.prio),
    .found_i     (best_found_q),
    .best_prio_i (best_prio_q),
    .hit_o       (pick_hit),
    .kind_o      (pick_kind),
    .prio_o      (pick_prio)
  );

  assign in_stall_o = (state_q != prr_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign issuing       = (issue_cnt_q != CW'(SLOTS + 1));
  assign scan_addr_nxt = (scan_addr_q == AW'(SLOTS - 1)) ? '0 : scan_addr_q + 1'b1;
  // The first row of a scan only offers the kinds after the last served one.
  assign eval_mask     = rd_first_q ? first_mask_q : prr_pkg::KindsAll;

  always_comb begin
    clear_row.kinds = '0;
    clear_row.pend  = '0;
    for (int k = 0; k < prr_pkg::KindCount; k++) begin
      clear_row.prio[k] = PrioInf;
      clear_row.ev[k]   = prr_pkg::EvAny;
    end
  end

  always_comb begin
    grant_row = best_row_q;
    grant_row.pend[best_kind_q] = 1'b0;
  end

  always_comb begin
    acc_mask   = prr_pkg::kind_mask(ev_q);
    rm_mask    = acc_mask & rd_row.kinds;
    row_mod    = rd_row;
    acc_we     = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    acc_status = prr_pkg::STAT_OK;
    case (req_q)
      prr_pkg::REQ_REGISTER: begin
        if (!slot_ok_q || acc_mask == prr_pkg::KindsNone ||
            acc_mask == prr_pkg::KindsAll) begin
          acc_status = prr_pkg::STAT_INVALID;
        end else if ((rd_row.kinds & acc_mask) != prr_pkg::KindsNone) begin
          acc_status = prr_pkg::STAT_HELD;
        end else begin
          acc_we        = 1'b1;
          cnt_inc       = (rd_row.kinds == prr_pkg::KindsNone);
          row_mod.kinds = rd_row.kinds | acc_mask;
          for (int k = 0; k < prr_pkg::KindCount; k++) begin
            if (acc_mask[k]) begin
              row_mod.prio[k] = prio_q;
              row_mod.ev[k]   = ev_q;
            end
          end
        end
      end
      prr_pkg::REQ_REMOVE: begin
        if (!slot_ok_q || rm_mask == prr_pkg::KindsNone) begin
          acc_status = prr_pkg::STAT_NONE;
        end else begin
          acc_we        = 1'b1;
          row_mod.kinds = rd_row.kinds & ~rm_mask;
          row_mod.pend  = rd_row.pend & ~rm_mask;
          for (int k = 0; k < prr_pkg::KindCount; k++) begin
            if (rm_mask[k]) begin
              row_mod.prio[k] = PrioInf;
            end
          end
          cnt_dec = (row_mod.kinds == prr_pkg::KindsNone) && (slot_count_q != '0);
        end
      end
      prr_pkg::REQ_READY: begin
        if (slot_ok_q) begin
          acc_we       = 1'b1;
          row_mod.pend = rd_row.pend | (rdy_q & rd_row.kinds);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = slot_addr_q;
    mem_wdata = row_mod;
    mem_raddr = scan_addr_q;
    case (state_q)
      prr_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = clear_row;
        if (clr_addr_q == AW'(SLOTS - 1)) begin
          state_d = prr_pkg::S_IDLE;
        end
      end
      prr_pkg::S_IDLE: begin
        mem_raddr = AW'(slot_i);
        if (in_xfer) begin
          if (prr_pkg::req_e'(req_type_i) == prr_pkg::REQ_GRANT) begin
            state_d = prr_pkg::S_SCAN;
          end else begin
            state_d = prr_pkg::S_ACCESS;
          end
        end
      end
      prr_pkg::S_ACCESS: begin
        mem_we  = acc_we;
        state_d = prr_pkg::S_DONE;
      end
      prr_pkg::S_SCAN: begin
        if (!issuing && !rd_vld_q) begin
          state_d = prr_pkg::S_GRANT;
        end
      end
      prr_pkg::S_GRANT: begin
        mem_we    = best_found_q;
        mem_waddr = best_slot_q;
        mem_wdata = grant_row;
        state_d   = prr_pkg::S_DONE;
      end
      prr_pkg::S_DONE: begin
        if (out_free) begin
          state_d = prr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prr_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      issue_cnt_q  <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      last_slot_q  <= '0;
      last_kind_q  <= '0;
      served_q     <= 1'b0;
      slot_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == prr_pkg::S_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      rd_vld_q <= (state_q == prr_pkg::S_SCAN) && issuing;
      if (in_xfer) begin
        issue_cnt_q  <= '0;
        best_found_q <= 1'b0;
      end else if (state_q == prr_pkg::S_SCAN && issuing) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
      if (rd_vld_q && pick_hit) begin
        best_found_q <= 1'b1;
      end
      if (state_q == prr_pkg::S_ACCESS) begin
        if (cnt_inc) begin
          slot_count_q <= slot_count_q + 1'b1;
        end else if (cnt_dec) begin
          slot_count_q <= slot_count_q - 1'b1;
        end
      end
      if (state_q == prr_pkg::S_GRANT && best_found_q) begin
        last_slot_q <= best_slot_q;
        last_kind_q <= best_kind_q;
        served_q    <= 1'b1;
      end
      if (state_q == prr_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q       <= prr_pkg::req_e'(req_type_i);
      slot_addr_q <= AW'(slot_i);
      slot_ok_q   <= (int'(slot_i) < SLOTS);
      ev_q        <= event_type_i;
      prio_q      <= PRIO_BITS'(prio_i);
      rdy_q       <= ready_bits_i;
      // Before the first grant the scan starts one slot behind slot 0 and
      // takes nothing from that first row.
      scan_addr_q <= served_q ? last_slot_q : AW'(SLOTS - 1);
      case (last_kind_q)
        prr_pkg::KindRead:  first_mask_q <= served_q ? 3'b110 : prr_pkg::KindsNone;
        prr_pkg::KindWrite: first_mask_q <= served_q ? 3'b100 : prr_pkg::KindsNone;
        default:            first_mask_q <= prr_pkg::KindsNone;
      endcase
    end else if (state_q == prr_pkg::S_SCAN && issuing) begin
      scan_addr_q <= scan_addr_nxt;
    end
    rd_first_q <= (issue_cnt_q == '0);
    rd_slot_q  <= scan_addr_q;
    if (rd_vld_q && pick_hit) begin
      best_slot_q <= rd_slot_q;
      best_kind_q <= pick_kind;
      best_prio_q <= pick_prio;
      best_row_q  <= rd_row;
    end
    if (state_q == prr_pkg::S_ACCESS) begin
      res_status_q <= acc_status;
      res_gv_q     <= 1'b0;
      res_gs_q     <= '0;
      res_gk_q     <= '0;
      res_ge_q     <= '0;
      res_gp_q     <= '0;
    end else if (state_q == prr_pkg::S_GRANT) begin
      res_status_q <= prr_pkg::STAT_OK;
      res_gv_q     <= best_found_q;
      res_gs_q     <= best_found_q ? 6'(best_slot_q) : '0;
      res_gk_q     <= best_found_q ? best_kind_q : '0;
      res_ge_q     <= best_found_q ? best_row_q.ev[best_kind_q] : '0;
      res_gp_q     <= best_found_q ? 8'(best_prio_q) : '0;
    end
    if (state_q == prr_pkg::S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_gv_q     <= res_gv_q;
      out_gs_q     <= res_gs_q;
      out_gk_q     <= res_gk_q;
      out_ge_q     <= res_ge_q;
      out_gp_q     <= res_gp_q;
      out_cnt_q    <= slot_count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_valid_o  = out_gv_q;
  assign grant_slot_o   = out_gs_q;
  assign grant_kind_o   = out_gk_q;
  assign grant_event_o  = out_ge_q;
  assign grant_prio_o   = out_gp_q;
  assign active_slots_o = out_cnt_q;

endmodule

@@ hdl/prr_checker.sv @@
module prr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic                       grant_valid_o,
  input logic [5:0]                 grant_slot_o,
  input logic [1:0]                 grant_kind_o,
  input logic [2:0]                 grant_event_o,
  input logic [7:0]                 grant_prio_o,
  input logic [prr_pkg::CountW-1:0] active_slots_o
);

  // A stalled result stays valid and keeps its status, grant valid, slot, priority and slot count.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(grant_valid_o) && $stable(grant_slot_o) && $stable(grant_prio_o) &&
    $stable(active_slots_o))
    else $error("stalled result changed");

  // A grant always reports success and a real kind.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grant_valid_o |->
    status_o == prr_pkg::STAT_OK && grant_kind_o <= prr_pkg::KindExc)
    else $error("grant with bad status or kind");

  // Without a grant every grant field is zero.
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !grant_valid_o |->
    grant_slot_o == '0 && grant_kind_o == '0 && grant_event_o == '0 &&
    grant_prio_o == '0)
    else $error("grant fields set without a grant");

  // The slot count cannot exceed the addressable slots.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> active_slots_o <= prr_pkg::CountW'(prr_pkg::MaxSlotCount))
    else $error("active slot count out of range");

endmodule

bind priority_round_robin_event_arbiter prr_checker u_prr_checker (.*);
